@@ hw/rtl/lcts_pkg.sv @@
// ----------------------------------------------------------------------------
// lcts_pkg: shared types and constants for the load-cell tare/scale core
// Field widths, codes, reset values and the serial divider control struct.
// ----------------------------------------------------------------------------
package lcts_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int CFG_W          = 7;
    localparam int WEIGHT_W       = 24;
    localparam int CCNT_W         = SAMPLE_BITS + 1;
    localparam int W_OUT_W        = 48;
    localparam int DIV_W          = W_OUT_W;
    localparam int STEP_W         = 6;

    localparam logic [CFG_W-1:0]    MEASURE_CNT_RST = 7'd10;
    localparam logic [CFG_W-1:0]    TARE_CNT_RST    = 7'd30;
    localparam logic [CFG_W-1:0]    CALIB_CNT_RST   = 7'd20;
    localparam logic [WEIGHT_W-1:0] CAL_WEIGHT_RST  = 24'd100;

    localparam logic [W_OUT_W-1:0] W_POS_MAX = {1'b0, {(W_OUT_W-1){1'b1}}};
    localparam logic [W_OUT_W-1:0] W_NEG_MIN = {1'b1, {(W_OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_MEASURE_COUNT = 2'd0,
        REG_TARE_COUNT    = 2'd1,
        REG_CALIB_COUNT   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TARE   = 2'd1,
        OP_CALIB  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_WEIGHT     = 2'd0,
        KIND_TARE_DONE  = 2'd1,
        KIND_CAL_DONE   = 2'd2,
        KIND_CAL_REJECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_TARE    = 2'd1,
        MODE_CALIB   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_DIFF,
        ST_MUL,
        ST_WDIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

@@ hw/rtl/lcts_sdiv.sv @@
// ----------------------------------------------------------------------------
// lcts_sdiv: bit-serial restoring divider
// Unsigned, one quotient bit per cycle. The dividend is left aligned so that
// the quotient ends up right aligned after the requested number of steps.
// ----------------------------------------------------------------------------
module lcts_sdiv
    import lcts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctl_t          ctl,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [CCNT_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  shift_reg, shift_next;
    logic [CCNT_W-1:0] rem_reg, rem_next;
    logic [CCNT_W-1:0] dvs_reg, dvs_next;
    logic [CCNT_W+1:0] trial;

    always_comb begin
        trial      = {1'b0, rem_reg, shift_reg[DIV_W-1]} - {2'b00, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (ctl.start) begin
            busy_next  = 1'b1;
            cnt_next   = ctl.steps;
            shift_next = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            // restore on borrow, otherwise keep the difference
            if (trial[CCNT_W+1]) begin
                rem_next = {rem_reg[CCNT_W-2:0], shift_reg[DIV_W-1]};
            end else begin
                rem_next = trial[CCNT_W-1:0];
            end
            shift_next = {shift_reg[DIV_W-2:0], ~trial[CCNT_W+1]};
            cnt_next   = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

@@ hw/rtl/load_cell_tare_scale_core.sv @@
// A sample that does not close a window leaves the core idle, so items may follow back to back.
// A closing tare or calibration sample passes the serial divider (average) and the difference step;
// a closing measure sample passes the serial divider (average, then weight) and the serial
// multiplier before its result is emitted. Input waits until the result is in the output register.
// Reset (aresetn low, synchronous) restores counts 10/30/20, zero offset, unity direction,
// cal_counts 1, cal_weight 100, measure mode and an empty window.
// ----------------------------------------------------------------------------
// load_cell_tare_scale_core: load-cell averaging, tare and calibration
// Averages converter samples over a window and turns each measure window
// into a calibrated weight in centigrams; tare and calibrate commands
// capture offset and scale from their own windows.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_core
    import lcts_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] raw_word, [47:24] reference mass (centigrams)
    input  logic [2:0]  s_tuser,   // [1:0] op, [2] timed_out
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [47:0] weight_cg, [71:48] offset_value
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] saturated
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int MUL_CNT_W = $clog2(WEIGHT_W + 1);
    localparam int MUL_HI_W  = CCNT_W + 1;

    function automatic logic [CNT_W-1:0] win_len(input logic [CFG_W-1:0] r);
        logic [CNT_W-1:0] len;
        if (r == '0) begin
            len = CNT_W'(1);
        end else if (32'(r) > MAX_WINDOW) begin
            len = CNT_W'(MAX_WINDOW);
        end else begin
            len = CNT_W'(r);
        end
        return len;
    endfunction

    // control and architectural state
    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [CFG_W-1:0]     meas_cnt_reg, meas_cnt_next;
    logic [CFG_W-1:0]     tare_cnt_reg, tare_cnt_next;
    logic [CFG_W-1:0]     calib_cnt_reg, calib_cnt_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] tare_reg, tare_next;
    logic                 sign_pos_reg, sign_pos_next;
    logic [CCNT_W-1:0]    cal_counts_reg, cal_counts_next;
    logic [WEIGHT_W-1:0]  cal_weight_reg, cal_weight_next;
    logic [WEIGHT_W-1:0]  pend_reg, pend_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg, mul_cnt_next;
    logic                 m_valid_reg, m_valid_next;

    // datapath
    logic                 avg_neg_reg, avg_neg_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic [CCNT_W-1:0]    mcand_reg, mcand_next;
    logic [MUL_HI_W-1:0]  mul_hi_reg, mul_hi_next;
    logic [WEIGHT_W-1:0]  mul_lo_reg, mul_lo_next;
    logic                 w_neg_reg, w_neg_next;
    kind_t                res_kind_reg, res_kind_next;
    logic [W_OUT_W-1:0]   res_w_reg, res_w_next;
    logic                 res_sat_reg, res_sat_next;
    kind_t                m_kind_reg, m_kind_next;
    logic [W_OUT_W-1:0]   m_w_reg, m_w_next;
    logic [SAMPLE_BITS-1:0] m_ofs_reg, m_ofs_next;
    logic                 m_sat_reg, m_sat_next;

    // combinational helpers
    op_t                     in_op;
    logic [SAMPLE_BITS-1:0]  in_raw;
    logic                    in_timed_out;
    logic [WEIGHT_W-1:0]     in_weight;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] sum_acc;
    logic [SUM_W-1:0]        sum_mag;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        cur_len;
    logic signed [CCNT_W-1:0] diff;
    logic [CCNT_W-1:0]       diff_mag;
    logic [MUL_HI_W-1:0]     mul_add;
    logic [SAMPLE_BITS-1:0]  avg_mag;

    div_ctl_t            div_ctl;
    logic [DIV_W-1:0]    div_dividend;
    logic [CCNT_W-1:0]   div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    lcts_sdiv u_sdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_op        = op_t'(s_tuser[1:0]);
    assign in_timed_out = s_tuser[2];
    assign in_raw       = s_tdata[23:0];
    assign in_weight    = s_tdata[47:24];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_ofs_reg, m_w_reg};
    assign m_tuser   = {m_sat_reg, m_kind_reg};

    // configuration registers
    always_comb begin
        meas_cnt_next  = meas_cnt_reg;
        tare_cnt_next  = tare_cnt_reg;
        calib_cnt_next = calib_cnt_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MEASURE_COUNT: meas_cnt_next  = cfg_data;
                REG_TARE_COUNT:    tare_cnt_next  = cfg_data;
                REG_CALIB_COUNT:   calib_cnt_next = cfg_data;
                REG_UNUSED:        ;
            endcase
        end
    end

    always_comb begin
        sample_ext = in_timed_out ? '0 : SUM_W'($signed(in_raw));
        sum_acc    = sum_reg + sample_ext;
        sum_mag    = sum_acc[SUM_W-1] ? -sum_acc : sum_acc;
        cnt_inc    = cnt_reg + CNT_W'(1);
        cur_len    = win_len(mode_reg == MODE_TARE  ? tare_cnt_reg :
                             mode_reg == MODE_CALIB ? calib_cnt_reg : meas_cnt_reg);
        diff       = CCNT_W'(avg_reg) - CCNT_W'(tare_reg);
        diff_mag   = diff[CCNT_W-1] ? -diff : diff;
        mul_add    = mul_hi_reg + (mul_lo_reg[0] ? {1'b0, mcand_reg} : '0);
        avg_mag    = div_q[SAMPLE_BITS-1:0];

        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        tare_next       = tare_reg;
        sign_pos_next   = sign_pos_reg;
        cal_counts_next = cal_counts_reg;
        cal_weight_next = cal_weight_reg;
        pend_next       = pend_reg;
        mul_cnt_next    = mul_cnt_reg;
        avg_neg_next    = avg_neg_reg;
        avg_next        = avg_reg;
        mcand_next      = mcand_reg;
        mul_hi_next     = mul_hi_reg;
        mul_lo_next     = mul_lo_reg;
        w_neg_next      = w_neg_reg;
        res_kind_next   = res_kind_reg;
        res_w_next      = res_w_reg;
        res_sat_next    = res_sat_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_w_next        = m_w_reg;
        m_ofs_next      = m_ofs_reg;
        m_sat_next      = m_sat_reg;
        div_ctl         = '0;
        div_dividend    = '0;
        div_divisor     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_SAMPLE: begin
                            if (cnt_inc < cur_len) begin
                                cnt_next = cnt_inc;
                                sum_next = sum_acc;
                            end else begin
                                // window closes: divide the magnitude, keep the sign
                                cnt_next      = '0;
                                sum_next      = '0;
                                avg_neg_next  = sum_acc[SUM_W-1];
                                div_ctl.start = 1'b1;
                                div_ctl.steps = STEP_W'(SUM_W);
                                div_dividend  = DIV_W'(sum_mag) << (DIV_W - SUM_W);
                                div_divisor   = CCNT_W'(cnt_inc);
                                state_next    = ST_AVG;
                            end
                        end
                        OP_TARE: begin
                            cnt_next  = '0;
                            sum_next  = '0;
                            mode_next = MODE_TARE;
                        end
                        OP_CALIB: begin
                            cnt_next  = '0;
                            sum_next  = '0;
                            pend_next = in_weight;
                            if (in_weight == '0) begin
                                mode_next     = MODE_MEASURE;
                                res_kind_next = KIND_CAL_REJECT;
                                res_w_next    = '0;
                                res_sat_next  = 1'b0;
                                state_next    = ST_EMIT;
                            end else begin
                                mode_next = MODE_CALIB;
                            end
                        end
                        OP_NONE: ;
                    endcase
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    avg_next   = avg_neg_reg ? -avg_mag : avg_mag;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                res_w_next   = '0;
                res_sat_next = 1'b0;
                unique case (mode_reg)
                    MODE_TARE: begin
                        tare_next     = avg_reg;
                        mode_next     = MODE_MEASURE;
                        res_kind_next = KIND_TARE_DONE;
                        state_next    = ST_EMIT;
                    end
                    MODE_CALIB: begin
                        mode_next  = MODE_MEASURE;
                        state_next = ST_EMIT;
                        if (diff == '0) begin
                            res_kind_next = KIND_CAL_REJECT;
                        end else begin
                            sign_pos_next   = !diff[CCNT_W-1];
                            cal_counts_next = diff_mag;
                            cal_weight_next = pend_reg;
                            res_kind_next   = KIND_CAL_DONE;
                        end
                    end
                    MODE_MEASURE: begin
                        mcand_next    = diff_mag;
                        mul_hi_next   = '0;
                        mul_lo_next   = cal_weight_reg;
                        mul_cnt_next  = MUL_CNT_W'(WEIGHT_W);
                        w_neg_next    = diff[CCNT_W-1] ^ !sign_pos_reg;
                        res_kind_next = KIND_WEIGHT;
                        state_next    = ST_MUL;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_MUL: begin
                if (mul_cnt_reg == '0) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEP_W'(DIV_W);
                    div_dividend  = {mul_hi_reg[W_OUT_W-WEIGHT_W-1:0], mul_lo_reg};
                    div_divisor   = cal_counts_reg;
                    state_next    = ST_WDIV;
                end else begin
                    // add on the low multiplier bit, then shift the pair right
                    mul_hi_next  = mul_add >> 1;
                    mul_lo_next  = {mul_add[0], mul_lo_reg[WEIGHT_W-1:1]};
                    mul_cnt_next = mul_cnt_reg - MUL_CNT_W'(1);
                end
            end
            ST_WDIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                    if (w_neg_reg) begin
                        if (div_q[W_OUT_W-1] && (div_q[W_OUT_W-2:0] != '0)) begin
                            res_w_next   = W_NEG_MIN;
                            res_sat_next = 1'b1;
                        end else begin
                            res_w_next   = -div_q;
                            res_sat_next = 1'b0;
                        end
                    end else if (div_q[W_OUT_W-1]) begin
                        res_w_next   = W_POS_MAX;
                        res_sat_next = 1'b1;
                    end else begin
                        res_w_next   = div_q;
                        res_sat_next = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_w_next     = res_w_reg;
                    m_ofs_next   = tare_reg;
                    m_sat_next   = res_sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_MEASURE;
            meas_cnt_reg   <= MEASURE_CNT_RST;
            tare_cnt_reg   <= TARE_CNT_RST;
            calib_cnt_reg  <= CALIB_CNT_RST;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            tare_reg       <= '0;
            sign_pos_reg   <= 1'b1;
            cal_counts_reg <= CCNT_W'(1);
            cal_weight_reg <= CAL_WEIGHT_RST;
            pend_reg       <= '0;
            mul_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            meas_cnt_reg   <= meas_cnt_next;
            tare_cnt_reg   <= tare_cnt_next;
            calib_cnt_reg  <= calib_cnt_next;
            cnt_reg        <= cnt_next;
            sum_reg        <= sum_next;
            tare_reg       <= tare_next;
            sign_pos_reg   <= sign_pos_next;
            cal_counts_reg <= cal_counts_next;
            cal_weight_reg <= cal_weight_next;
            pend_reg       <= pend_next;
            mul_cnt_reg    <= mul_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_neg_reg  <= avg_neg_next;
        avg_reg      <= avg_next;
        mcand_reg    <= mcand_next;
        mul_hi_reg   <= mul_hi_next;
        mul_lo_reg   <= mul_lo_next;
        w_neg_reg    <= w_neg_next;
        res_kind_reg <= res_kind_next;
        res_w_reg    <= res_w_next;
        res_sat_reg  <= res_sat_next;
        m_kind_reg   <= m_kind_next;
        m_w_reg      <= m_w_next;
        m_ofs_reg    <= m_ofs_next;
        m_sat_reg    <= m_sat_next;
    end

`ifndef NO_ASSERTIONS
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_AVG || state_reg == ST_WDIV))
        else $error("divider finished outside a divide state");

    a_cal_counts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_counts_reg != '0)
        else $error("calibration counts reached zero");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) < MAX_WINDOW)
        else $error("window count ran past its length");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_sat_reg) |-> (m_w_reg == W_POS_MAX || m_w_reg == W_NEG_MIN))
        else $error("saturated weight not at a range limit");
`endif

endmodule
